// ----- rtl/sdr_pkg.sv -----
// Shared constants, types and fixed-point helpers for the Dirichlet residual core.
`timescale 1ns / 1ps

package sdr_pkg;

    localparam int FRAC_BITS = 16;

    // restoring divider: one quotient bit per stage, 32-bit saturating quotient
    localparam int DIV_LAT = 32;
    localparam int DIV_DW  = 63;
    localparam int DIV_NW  = (33 + 2 * FRAC_BITS > 64) ? 33 + 2 * FRAC_BITS : 64;
    localparam int DIV_CW  = DIV_DW + DIV_LAT - 1;

    // width of a 64-bit product after the fractional floor shift
    localparam int PFW = 64 - FRAC_BITS;

    // input register, three dividers, nine single stages, output register
    localparam int TOTAL_LAT = 3 * DIV_LAT + 11;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_UNIT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TERM_WEIGHT = 2'd1;

    localparam logic [30:0] ONE_U = 31'd1 << FRAC_BITS;
    localparam logic signed [65:0] ONE_W  = 66'sd1 <<< FRAC_BITS;
    localparam logic signed [65:0] FOUR_W = 66'sd4 <<< FRAC_BITS;

    // 2^-30 in Q2F, at least one LSB
    localparam logic [DIV_DW-1:0] EPS_Q2 =
        DIV_DW'(1) << ((2 * FRAC_BITS > 30) ? 2 * FRAC_BITS - 30 : 0);

    typedef logic signed [31:0] s32_t;

    function automatic s32_t sat32(input logic signed [65:0] x);
        s32_t r;
        if (x > 66'sh0_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end
        else if (x < -66'sh0_8000_0000) begin
            r = 32'sh8000_0000;
        end
        else begin
            r = 32'(x);
        end
        return r;
    endfunction

    function automatic logic [DIV_NW-1:0] mag(input logic signed [DIV_NW-1:0] x);
        return x[DIV_NW-1] ? DIV_NW'(-x) : DIV_NW'(x);
    endfunction

    // quotient magnitude (saturated at 2^31) to a truncated, saturated signed value
    function automatic s32_t quo_trunc(input logic [31:0] q, input logic neg);
        s32_t r;
        if (neg) begin
            r = s32_t'(-q);
        end
        else begin
            r = q[31] ? 32'sh7FFF_FFFF : s32_t'(q);
        end
        return r;
    endfunction

    // same with the magnitude capped at 2^31-1 on both sides
    function automatic s32_t quo_sym(input logic [31:0] q, input logic neg);
        logic [31:0] m;
        m = q[31] ? 32'h7FFF_FFFF : q;
        return neg ? s32_t'(-m) : s32_t'(m);
    endfunction

endpackage

// ----- rtl/sdr_div.sv -----
// Pipelined restoring divider: min(num / den, 2^31), one quotient bit per stage.
`timescale 1ns / 1ps

module sdr_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [sdr_pkg::DIV_NW-1:0]    num,
    input  logic [sdr_pkg::DIV_DW-1:0]    den,
    output logic                          out_valid,
    output logic [31:0]                   quo
);

    logic                         vld_reg [sdr_pkg::DIV_LAT];
    logic [sdr_pkg::DIV_NW-1:0]   rem_reg [sdr_pkg::DIV_LAT];
    logic [sdr_pkg::DIV_DW-1:0]   den_reg [sdr_pkg::DIV_LAT];
    logic [31:0]                  quo_reg [sdr_pkg::DIV_LAT];
    logic                         sat_next;

    // quotient of 2^31 or more: saturate, later stages add nothing
    assign sat_next = sdr_pkg::DIV_CW'(num)
                      >= (sdr_pkg::DIV_CW'(den) << (sdr_pkg::DIV_LAT - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= num;
        den_reg[0] <= den;
        quo_reg[0] <= sat_next ? 32'h8000_0000 : 32'h0;
    end

    for (genvar j = 1; j < sdr_pkg::DIV_LAT; j++)
    begin : g_stage
        localparam int K = sdr_pkg::DIV_LAT - 1 - j;
        logic [sdr_pkg::DIV_CW-1:0] trial;
        logic                       take_next;
        logic [sdr_pkg::DIV_NW-1:0] rem_next;
        logic [31:0]                quo_next;

        assign trial     = sdr_pkg::DIV_CW'(den_reg[j-1]) << K;
        assign take_next = !quo_reg[j-1][31]
                           && (sdr_pkg::DIV_CW'(rem_reg[j-1]) >= trial);
        assign rem_next  = take_next
                           ? sdr_pkg::DIV_NW'(sdr_pkg::DIV_CW'(rem_reg[j-1]) - trial)
                           : rem_reg[j-1];
        assign quo_next  = quo_reg[j-1] | (32'(take_next) << K);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j] <= 1'b0;
            end
            else
            begin
                vld_reg[j] <= vld_reg[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[j] <= rem_next;
            den_reg[j] <= den_reg[j-1];
            quo_reg[j] <= quo_next;
        end
    end

    assign out_valid = vld_reg[sdr_pkg::DIV_LAT-1];
    assign quo       = quo_reg[sdr_pkg::DIV_LAT-1];

endmodule

// ----- rtl/symmetric_dirichlet_residual_grad_core.sv -----
// Top level: symmetric Dirichlet residual and nine-entry gradient, fully pipelined.
`timescale 1ns / 1ps
//
// Usage
// - Input beat: base, u-neighbour and v-neighbour points (Q16.16) are taken
//   at each rising edge with start high; busy is always low, so a new beat
//   may be offered every cycle.
// - Result beat: done pulses for one cycle with residual and the nine
//   gradient entries valid in that cycle. The receiver cannot hold results
//   off; none is needed, since the pipeline never stalls.
// - Throughput: one beat per cycle. Most of the depth from start to done
//   lies in the three chains of bit-serial divider stages (edge scaling,
//   division by the determinant, final division by the grid unit), 32
//   stages each.
// - Config: cfg_valid/cfg_ready write channel, cfg_ready always high.
//   Index 0 grid_unit, 1 term_weight, others ignored. Write only while idle.
// - Reset: pipeline valid bits clear, both registers return to 1.0.
//   No state survives between beats.
//

module symmetric_dirichlet_residual_grad_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [31:0]                 base_x,
    input  logic signed [31:0]                 base_y,
    input  logic signed [31:0]                 base_z,
    input  logic signed [31:0]                 unbr_x,
    input  logic signed [31:0]                 unbr_y,
    input  logic signed [31:0]                 unbr_z,
    input  logic signed [31:0]                 vnbr_x,
    input  logic signed [31:0]                 vnbr_y,
    input  logic signed [31:0]                 vnbr_z,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sdr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [30:0]                        cfg_data,
    output logic                               done,
    output logic signed [31:0]                 residual,
    output logic signed [31:0]                 grad_base_x,
    output logic signed [31:0]                 grad_base_y,
    output logic signed [31:0]                 grad_base_z,
    output logic signed [31:0]                 grad_unbr_x,
    output logic signed [31:0]                 grad_unbr_y,
    output logic signed [31:0]                 grad_unbr_z,
    output logic signed [31:0]                 grad_vnbr_x,
    output logic signed [31:0]                 grad_vnbr_y,
    output logic signed [31:0]                 grad_vnbr_z
);

    localparam int F   = sdr_pkg::FRAC_BITS;
    localparam int LAT = sdr_pkg::DIV_LAT;
    localparam int NW  = sdr_pkg::DIV_NW;
    localparam int PW  = sdr_pkg::PFW;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    logic [30:0]               grid_unit_reg;
    logic [30:0]               term_weight_reg;
    logic [30:0]               unit_eff;
    logic [sdr_pkg::DIV_DW-1:0] unit_den;
    logic signed [31:0]        wgt;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_unit_reg   <= sdr_pkg::ONE_U;
            term_weight_reg <= sdr_pkg::ONE_U;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                sdr_pkg::CFG_GRID_UNIT:   grid_unit_reg   <= cfg_data;
                sdr_pkg::CFG_TERM_WEIGHT: term_weight_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // a zero grid unit acts as one LSB
    assign unit_eff = (grid_unit_reg == 31'd0) ? 31'd1 : grid_unit_reg;
    assign unit_den = sdr_pkg::DIV_DW'(unit_eff);
    assign wgt      = $signed({1'b0, term_weight_reg});

    // ------------------------------------------------------------------
    // S0: edge differences
    // ------------------------------------------------------------------
    logic signed [31:0] base_v [3];
    logic signed [31:0] unbr_v [3];
    logic signed [31:0] vnbr_v [3];
    logic               v0_reg;
    logic signed [32:0] d0_reg  [6];
    logic signed [32:0] d0_next [6];

    assign base_v[0] = base_x;
    assign base_v[1] = base_y;
    assign base_v[2] = base_z;
    assign unbr_v[0] = unbr_x;
    assign unbr_v[1] = unbr_y;
    assign unbr_v[2] = unbr_z;
    assign vnbr_v[0] = vnbr_x;
    assign vnbr_v[1] = vnbr_y;
    assign vnbr_v[2] = vnbr_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d0_next[i]     = 33'(unbr_v[i]) - 33'(base_v[i]);
            d0_next[3 + i] = 33'(vnbr_v[i]) - 33'(base_v[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        d0_reg <= d0_next;
    end

    // ------------------------------------------------------------------
    // D1: eu, ev = diff * 2^F / unit, truncated toward zero
    // ------------------------------------------------------------------
    logic [NW-1:0] n1     [6];
    logic [31:0]   q1     [6];
    logic [5:0]    v1;
    logic [5:0]    s1_sgn_reg [LAT];

    for (genvar i = 0; i < 6; i++)
    begin : g_d1
        assign n1[i] = sdr_pkg::mag(NW'(d0_reg[i])) << F;
        sdr_div u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (v0_reg),
            .num       (n1[i]),
            .den       (unit_den),
            .out_valid (v1[i]),
            .quo       (q1[i])
        );
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 6; i++)
        begin
            s1_sgn_reg[0][i] <= d0_reg[i][32];
        end
        for (int k = 1; k < LAT; k++)
        begin
            s1_sgn_reg[k] <= s1_sgn_reg[k-1];
        end
    end

    // ------------------------------------------------------------------
    // S2: per-axis products of the form entries
    // ------------------------------------------------------------------
    sdr_pkg::s32_t      e1_next [6];
    logic               v2_reg;
    sdr_pkg::s32_t      e2_reg  [6];
    logic signed [PW-1:0] paa_reg [3];
    logic signed [PW-1:0] pab_reg [3];
    logic signed [PW-1:0] pcc_reg [3];

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            e1_next[i] = sdr_pkg::quo_trunc(q1[i], s1_sgn_reg[LAT-1][i]);
        end
    end

    always_ff @(posedge clk)
    begin
        e2_reg <= e1_next;
        for (int i = 0; i < 3; i++)
        begin
            paa_reg[i] <= PW'((64'(e1_next[i]) * 64'(e1_next[i])) >>> F);
            pab_reg[i] <= PW'((64'(e1_next[i]) * 64'(e1_next[3 + i])) >>> F);
            pcc_reg[i] <= PW'((64'(e1_next[3 + i]) * 64'(e1_next[3 + i])) >>> F);
        end
    end

    // ------------------------------------------------------------------
    // S3: a, b, c
    // ------------------------------------------------------------------
    logic          v3_reg;
    sdr_pkg::s32_t e3_reg [6];
    sdr_pkg::s32_t a3_reg, b3_reg, c3_reg;

    always_ff @(posedge clk)
    begin
        e3_reg <= e2_reg;
        a3_reg <= sdr_pkg::sat32(66'(paa_reg[0]) + 66'(paa_reg[1]) + 66'(paa_reg[2]));
        b3_reg <= sdr_pkg::sat32(66'(pab_reg[0]) + 66'(pab_reg[1]) + 66'(pab_reg[2]));
        c3_reg <= sdr_pkg::sat32(66'(pcc_reg[0]) + 66'(pcc_reg[1]) + 66'(pcc_reg[2]));
    end

    // ------------------------------------------------------------------
    // S4: a*c, b*b, trace
    // ------------------------------------------------------------------
    logic               v4_reg;
    sdr_pkg::s32_t      e4_reg [6];
    sdr_pkg::s32_t      a4_reg, b4_reg, c4_reg;
    logic signed [63:0] ac4_reg, bb4_reg;
    logic signed [32:0] tr4_reg;

    always_ff @(posedge clk)
    begin
        e4_reg  <= e3_reg;
        a4_reg  <= a3_reg;
        b4_reg  <= b3_reg;
        c4_reg  <= c3_reg;
        ac4_reg <= 64'(a3_reg) * 64'(c3_reg);
        bb4_reg <= 64'(b3_reg) * 64'(b3_reg);
        tr4_reg <= 33'(a3_reg) + 33'(c3_reg);
    end

    // ------------------------------------------------------------------
    // S5: determinant and clamp
    // ------------------------------------------------------------------
    logic signed [63:0]          det_next;
    logic                        clamp_next;
    logic                        v5_reg;
    sdr_pkg::s32_t               e5_reg [6];
    sdr_pkg::s32_t               a5_reg, b5_reg, c5_reg;
    logic signed [32:0]          tr5_reg;
    logic [sdr_pkg::DIV_DW-1:0]  det5_reg;
    logic                        clamp5_reg;

    assign det_next   = ac4_reg - bb4_reg;
    assign clamp_next = det_next <= $signed(64'(sdr_pkg::EPS_Q2));

    always_ff @(posedge clk)
    begin
        e5_reg     <= e4_reg;
        a5_reg     <= a4_reg;
        b5_reg     <= b4_reg;
        c5_reg     <= c4_reg;
        tr5_reg    <= tr4_reg;
        clamp5_reg <= clamp_next;
        det5_reg   <= clamp_next ? sdr_pkg::EPS_Q2 : sdr_pkg::DIV_DW'(det_next);
    end

    // ------------------------------------------------------------------
    // D2: tr, 1, a, b, c over det, each scaled by 2^2F
    // ------------------------------------------------------------------
    logic [NW-1:0]      n2 [5];
    logic [31:0]        q2 [5];
    logic [4:0]         v2;
    sdr_pkg::s32_t      s2_e_reg     [LAT][6];
    logic signed [32:0] s2_tr_reg    [LAT];
    logic [4:0]         s2_sgn_reg   [LAT];
    logic               s2_clamp_reg [LAT];

    assign n2[0] = sdr_pkg::mag(NW'(tr5_reg)) << (2 * F);
    assign n2[1] = NW'(1) << (3 * F);
    assign n2[2] = sdr_pkg::mag(NW'(a5_reg)) << (2 * F);
    assign n2[3] = sdr_pkg::mag(NW'(b5_reg)) << (2 * F);
    assign n2[4] = sdr_pkg::mag(NW'(c5_reg)) << (2 * F);

    for (genvar i = 0; i < 5; i++)
    begin : g_d2
        sdr_div u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (v5_reg),
            .num       (n2[i]),
            .den       (det5_reg),
            .out_valid (v2[i]),
            .quo       (q2[i])
        );
    end

    always_ff @(posedge clk)
    begin
        s2_e_reg[0]     <= e5_reg;
        s2_tr_reg[0]    <= tr5_reg;
        s2_sgn_reg[0]   <= {c5_reg[31], b5_reg[31], a5_reg[31], 1'b0, tr5_reg[32]};
        s2_clamp_reg[0] <= clamp5_reg;
        for (int k = 1; k < LAT; k++)
        begin
            s2_e_reg[k]     <= s2_e_reg[k-1];
            s2_tr_reg[k]    <= s2_tr_reg[k-1];
            s2_sgn_reg[k]   <= s2_sgn_reg[k-1];
            s2_clamp_reg[k] <= s2_clamp_reg[k-1];
        end
    end

    // ------------------------------------------------------------------
    // S6: Q*Ic, Q*Ib, Q*Ia, unweighted residual
    // ------------------------------------------------------------------
    sdr_pkg::s32_t        qt_next, inv_next, ia_next, ib_next, ic_next;
    logic                 v6_reg;
    sdr_pkg::s32_t        e6_reg [6];
    sdr_pkg::s32_t        inv6_reg, r6_reg;
    logic signed [PW-1:0] pqc6_reg, pqb6_reg, pqa6_reg;
    logic                 clamp6_reg;

    assign qt_next  = sdr_pkg::quo_sym(q2[0], s2_sgn_reg[LAT-1][0]);
    assign inv_next = sdr_pkg::quo_sym(q2[1], s2_sgn_reg[LAT-1][1]);
    assign ia_next  = sdr_pkg::quo_sym(q2[2], s2_sgn_reg[LAT-1][2]);
    assign ib_next  = sdr_pkg::quo_sym(q2[3], s2_sgn_reg[LAT-1][3]);
    assign ic_next  = sdr_pkg::quo_sym(q2[4], s2_sgn_reg[LAT-1][4]);

    always_ff @(posedge clk)
    begin
        e6_reg     <= s2_e_reg[LAT-1];
        clamp6_reg <= s2_clamp_reg[LAT-1];
        inv6_reg   <= inv_next;
        pqc6_reg   <= PW'((64'(qt_next) * 64'(ic_next)) >>> F);
        pqb6_reg   <= PW'((64'(qt_next) * 64'(ib_next)) >>> F);
        pqa6_reg   <= PW'((64'(qt_next) * 64'(ia_next)) >>> F);
        r6_reg     <= sdr_pkg::sat32(66'(s2_tr_reg[LAT-1]) + 66'(qt_next)
                                     - sdr_pkg::FOUR_W);
    end

    // ------------------------------------------------------------------
    // S7: energy partials; clamped determinant drops its derivative terms
    // ------------------------------------------------------------------
    logic signed [65:0] base_next;
    logic               v7_reg;
    sdr_pkg::s32_t      e7_reg [6];
    sdr_pkg::s32_t      dea7_reg, deb7_reg, dec7_reg;
    logic signed [63:0] wr7_reg;

    assign base_next = sdr_pkg::ONE_W + 66'(inv6_reg);

    always_ff @(posedge clk)
    begin
        e7_reg  <= e6_reg;
        wr7_reg <= 64'(wgt) * 64'(r6_reg);
        if (clamp6_reg)
        begin
            dea7_reg <= sdr_pkg::sat32(base_next);
            deb7_reg <= 32'sd0;
            dec7_reg <= sdr_pkg::sat32(base_next);
        end
        else
        begin
            dea7_reg <= sdr_pkg::sat32(base_next - 66'(pqc6_reg));
            deb7_reg <= sdr_pkg::sat32(66'(pqb6_reg) <<< 1);
            dec7_reg <= sdr_pkg::sat32(base_next - 66'(pqa6_reg));
        end
    end

    // ------------------------------------------------------------------
    // S8: chain rule products, weighted residual
    // ------------------------------------------------------------------
    logic                 v8_reg;
    sdr_pkg::s32_t        res8_reg;
    logic signed [PW-1:0] fa8_reg [3];
    logic signed [PW-1:0] fb8_reg [3];
    logic signed [PW-1:0] fc8_reg [3];
    logic signed [PW-1:0] fd8_reg [3];

    always_ff @(posedge clk)
    begin
        res8_reg <= sdr_pkg::sat32(66'(wr7_reg >>> F));
        for (int i = 0; i < 3; i++)
        begin
            fa8_reg[i] <= PW'((64'(dea7_reg) * 64'(e7_reg[i])) >>> F);
            fb8_reg[i] <= PW'((64'(deb7_reg) * 64'(e7_reg[3 + i])) >>> F);
            fc8_reg[i] <= PW'((64'(deb7_reg) * 64'(e7_reg[i])) >>> F);
            fd8_reg[i] <= PW'((64'(dec7_reg) * 64'(e7_reg[3 + i])) >>> F);
        end
    end

    // ------------------------------------------------------------------
    // S9: derivatives by eu and ev, mapped to the three points
    // ------------------------------------------------------------------
    logic signed [65:0] deu_next [3];
    logic signed [65:0] dev_next [3];
    logic               v9_reg;
    sdr_pkg::s32_t      res9_reg;
    sdr_pkg::s32_t      x9_reg [9];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            deu_next[i] = (66'(fa8_reg[i]) <<< 1) + 66'(fb8_reg[i]);
            dev_next[i] = 66'(fc8_reg[i]) + (66'(fd8_reg[i]) <<< 1);
        end
    end

    always_ff @(posedge clk)
    begin
        res9_reg <= res8_reg;
        for (int i = 0; i < 3; i++)
        begin
            x9_reg[i]     <= sdr_pkg::sat32(-(deu_next[i] + dev_next[i]));
            x9_reg[3 + i] <= sdr_pkg::sat32(deu_next[i]);
            x9_reg[6 + i] <= sdr_pkg::sat32(dev_next[i]);
        end
    end

    // ------------------------------------------------------------------
    // S10: weight
    // ------------------------------------------------------------------
    logic               v10_reg;
    sdr_pkg::s32_t      res10_reg;
    logic signed [63:0] wx10_reg [9];

    always_ff @(posedge clk)
    begin
        res10_reg <= res9_reg;
        for (int i = 0; i < 9; i++)
        begin
            wx10_reg[i] <= 64'(wgt) * 64'(x9_reg[i]);
        end
    end

    // S2..S10 valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            v5_reg  <= 1'b0;
            v6_reg  <= 1'b0;
            v7_reg  <= 1'b0;
            v8_reg  <= 1'b0;
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
        end
        else
        begin
            v2_reg  <= &v1;
            v3_reg  <= v2_reg;
            v4_reg  <= v3_reg;
            v5_reg  <= v4_reg;
            v6_reg  <= &v2;
            v7_reg  <= v6_reg;
            v8_reg  <= v7_reg;
            v9_reg  <= v8_reg;
            v10_reg <= v9_reg;
        end
    end

    // ------------------------------------------------------------------
    // D3: w*X / unit, truncated toward zero
    // ------------------------------------------------------------------
    logic [NW-1:0]  n3 [9];
    logic [31:0]    q3 [9];
    logic [8:0]     v3;
    logic [8:0]     s3_sgn_reg [LAT];
    sdr_pkg::s32_t  s3_res_reg [LAT];

    for (genvar i = 0; i < 9; i++)
    begin : g_d3
        assign n3[i] = sdr_pkg::mag(NW'(wx10_reg[i]));
        sdr_div u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (v10_reg),
            .num       (n3[i]),
            .den       (unit_den),
            .out_valid (v3[i]),
            .quo       (q3[i])
        );
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 9; i++)
        begin
            s3_sgn_reg[0][i] <= wx10_reg[i][63];
        end
        s3_res_reg[0] <= res10_reg;
        for (int k = 1; k < LAT; k++)
        begin
            s3_sgn_reg[k] <= s3_sgn_reg[k-1];
            s3_res_reg[k] <= s3_res_reg[k-1];
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic          done_reg;
    sdr_pkg::s32_t residual_reg;
    sdr_pkg::s32_t grad_reg [9];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= &v3;
        end
    end

    always_ff @(posedge clk)
    begin
        residual_reg <= s3_res_reg[LAT-1];
        for (int i = 0; i < 9; i++)
        begin
            grad_reg[i] <= sdr_pkg::quo_trunc(q3[i], s3_sgn_reg[LAT-1][i]);
        end
    end

    assign done        = done_reg;
    assign residual    = residual_reg;
    assign grad_base_x = grad_reg[0];
    assign grad_base_y = grad_reg[1];
    assign grad_base_z = grad_reg[2];
    assign grad_unbr_x = grad_reg[3];
    assign grad_unbr_y = grad_reg[4];
    assign grad_unbr_z = grad_reg[5];
    assign grad_vnbr_x = grad_reg[6];
    assign grad_vnbr_y = grad_reg[7];
    assign grad_vnbr_z = grad_reg[8];

`ifndef ASSERT_OFF
    // every accepted input beat produces a result beat at the end of the whole pipe
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##(sdr_pkg::TOTAL_LAT) done)
        else $error("result beat missing after fixed latency");

    // no result beat without a matching input beat
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, sdr_pkg::TOTAL_LAT))
        else $error("result beat without input beat");

    // clamped determinant drops the b partial
    a_clamp_deb: assert property (@(posedge clk) disable iff (!rst_n)
        v6_reg && clamp6_reg |=> deb7_reg == 32'sd0)
        else $error("b partial not dropped on clamped determinant");
`endif

endmodule
